/* rtl/cts_pkg.sv */
// ----------------------------------------------------------------------------
// cts_pkg
// shared types, codes and widths of the calculator token scanner
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int CH_W   = 8;
  localparam int KIND_W = 4;
  localparam int INT_W  = 64;
  localparam int FRAC_W = 60;
  localparam int FLEN_W = 5;

  localparam int CTS_MAX_IDENT       = 32;
  localparam int CTS_MAX_FRAC_DIGITS = 18;
  localparam int CTS_QUEUE_DEPTH     = 4;

  // token kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB    = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL    = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIV    = 4'd3;
  localparam logic [KIND_W-1:0] KIND_LPAR   = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RPAR   = 4'd5;
  localparam logic [KIND_W-1:0] KIND_COMMA  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 4'd7;
  localparam logic [KIND_W-1:0] KIND_INT    = 4'd8;
  localparam logic [KIND_W-1:0] KIND_DEC    = 4'd9;
  localparam logic [KIND_W-1:0] KIND_SYM    = 4'd10;
  localparam logic [KIND_W-1:0] KIND_END    = 4'd11;

  // character classes
  localparam logic [2:0] CL_OTHER  = 3'd0;
  localparam logic [2:0] CL_OP     = 3'd1;
  localparam logic [2:0] CL_WORD   = 3'd2;  // letter or underscore
  localparam logic [2:0] CL_DIGIT  = 3'd3;
  localparam logic [2:0] CL_DOT    = 3'd4;
  localparam logic [2:0] CL_END    = 3'd5;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CH_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CH_W-1:0] CH_UNDER = 8'h5f;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2a;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2f;
  localparam logic [CH_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
  localparam logic [CH_W-1:0] CH_EQ    = 8'h3d;

  typedef struct packed {
    logic [2:0]        cls;
    logic [KIND_W-1:0] opk;
    logic [CH_W-1:0]   ch;
  } cts_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } cts_qstat_t;

endpackage

/* rtl/cts_front.sv */
// ----------------------------------------------------------------------------
// cts_front
// accepts characters and classifies them into queue items
// ----------------------------------------------------------------------------
module cts_front (
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [cts_pkg::CH_W-1:0] in_ch,
  input  logic                     in_end_of_text,
  input  cts_pkg::cts_qstat_t      qstat,
  output logic                     push,
  output cts_pkg::cts_item_t       push_item
);
  import cts_pkg::*;

  logic is_digit;
  logic is_word;

  assign in_ready = !qstat.full;
  assign push     = in_valid && in_ready;

  assign is_digit = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
  assign is_word  = ((in_ch >= CH_UP_A) && (in_ch <= CH_UP_Z)) ||
                    ((in_ch >= CH_LO_A) && (in_ch <= CH_LO_Z)) ||
                    (in_ch == CH_UNDER);

  always_comb begin
    push_item.ch  = in_ch;
    push_item.opk = KIND_ADD;
    push_item.cls = CL_OTHER;
    if (in_end_of_text) begin
      push_item.cls = CL_END;
    end else if (is_digit) begin
      push_item.cls = CL_DIGIT;
    end else if (is_word) begin
      push_item.cls = CL_WORD;
    end else if (in_ch == CH_DOT) begin
      push_item.cls = CL_DOT;
    end else begin
      push_item.cls = CL_OP;
      unique case (in_ch)
        CH_PLUS:  push_item.opk = KIND_ADD;
        CH_MINUS: push_item.opk = KIND_SUB;
        CH_STAR:  push_item.opk = KIND_MUL;
        CH_SLASH: push_item.opk = KIND_DIV;
        CH_LPAR:  push_item.opk = KIND_LPAR;
        CH_RPAR:  push_item.opk = KIND_RPAR;
        CH_COMMA: push_item.opk = KIND_COMMA;
        CH_EQ:    push_item.opk = KIND_ASSIGN;
        default:  push_item.cls = CL_OTHER;
      endcase
    end
  end

endmodule

/* rtl/cts_queue.sv */
// ----------------------------------------------------------------------------
// cts_queue
// small fifo of classified characters between front and back
// ----------------------------------------------------------------------------
module cts_queue #(
  parameter int DEPTH = cts_pkg::CTS_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cts_pkg::cts_item_t  push_item,
  input  logic                pop,
  output cts_pkg::cts_item_t  head,
  output cts_pkg::cts_qstat_t qstat
);
  import cts_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cts_item_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign head        = slot_r[rd_ptr_r];
  assign qstat.full  = (cnt_r == CNT_W'(DEPTH));
  assign qstat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* rtl/cts_back.sv */
// ----------------------------------------------------------------------------
// cts_back
// scan state, identifier buffer and token emission through an output register
// ----------------------------------------------------------------------------
module cts_back #(
  parameter int MAX_IDENT       = cts_pkg::CTS_MAX_IDENT,
  parameter int MAX_FRAC_DIGITS = cts_pkg::CTS_MAX_FRAC_DIGITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cts_pkg::cts_item_t         head,
  input  cts_pkg::cts_qstat_t        qstat,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cts_pkg::KIND_W-1:0] out_kind,
  output logic [cts_pkg::CH_W-1:0]   out_char_value,
  output logic [cts_pkg::INT_W-1:0]  out_int_value,
  output logic [cts_pkg::FRAC_W-1:0] out_fraction_value,
  output logic [cts_pkg::FLEN_W-1:0] out_fraction_length,
  output logic                       out_ident_truncated,
  output logic                       out_last
);
  import cts_pkg::*;

  localparam int IDX_W = (MAX_IDENT > 1) ? $clog2(MAX_IDENT) : 1;
  localparam int LEN_W = $clog2(MAX_IDENT + 1);

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_IDENT = 2'd1;
  localparam logic [1:0] MODE_INT   = 2'd2;
  localparam logic [1:0] MODE_FRAC  = 2'd3;

  localparam logic ST_SCAN = 1'b0;
  localparam logic ST_SYM  = 1'b1;

  logic               st_r, st_nxt;
  logic [1:0]         mode_r, mode_nxt;
  logic [INT_W-1:0]   int_acc_r, int_acc_nxt;
  logic [FRAC_W-1:0]  frac_acc_r, frac_acc_nxt;
  logic [FLEN_W-1:0]  frac_cnt_r, frac_cnt_nxt;
  logic [LEN_W-1:0]   id_len_r, id_len_nxt;
  logic               trunc_r, trunc_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;

  logic [CH_W-1:0]    buf_mem [MAX_IDENT];
  logic [CH_W-1:0]    rdata_r;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [CH_W-1:0]    wr_data;
  logic               wr_en;

  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r, o_kind;
  logic [CH_W-1:0]    out_char_r, o_char;
  logic [INT_W-1:0]   out_int_r, o_int;
  logic [FRAC_W-1:0]  out_frac_r, o_frac;
  logic [FLEN_W-1:0]  out_flen_r, o_flen;
  logic               out_trunc_r, o_trunc;
  logic               out_last_r, o_last;
  logic               load;

  logic               emit_ok;
  logic               follow;
  logic               sym_last;
  logic [3:0]         digit;
  logic [INT_W-1:0]   int_times10;
  logic [FRAC_W-1:0]  frac_times10;

  assign emit_ok  = !out_valid_r || out_ready;
  // the pending item itself produces a result after the flush
  assign follow   = (head.cls == CL_OP) || (head.cls == CL_END);
  assign sym_last = ((LEN_W'(idx_r) + 1'b1) == id_len_r);
  assign digit    = head.ch[3:0];

  // times ten as two shifted adds
  assign int_times10  = {int_acc_r[INT_W-4:0], 3'b000} + {int_acc_r[INT_W-2:0], 1'b0};
  assign frac_times10 = {frac_acc_r[FRAC_W-4:0], 3'b000} + {frac_acc_r[FRAC_W-2:0], 1'b0};

  always_comb begin
    st_nxt       = st_r;
    mode_nxt     = mode_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    frac_cnt_nxt = frac_cnt_r;
    id_len_nxt   = id_len_r;
    trunc_nxt    = trunc_r;
    idx_nxt      = idx_r;
    rd_addr      = idx_r;
    wr_en        = 1'b0;
    wr_addr      = id_len_r[IDX_W-1:0];
    wr_data      = head.ch;
    pop          = 1'b0;
    load         = 1'b0;
    o_kind       = KIND_ADD;
    o_char       = '0;
    o_int        = '0;
    o_frac       = '0;
    o_flen       = '0;
    o_trunc      = 1'b0;
    o_last       = 1'b0;

    if (st_r == ST_SYM) begin
      if (emit_ok) begin
        load    = 1'b1;
        o_kind  = KIND_SYM;
        o_char  = rdata_r;
        o_trunc = trunc_r;
        o_last  = sym_last && !follow;
        if (sym_last) begin
          st_nxt     = ST_SCAN;
          mode_nxt   = MODE_IDLE;
          id_len_nxt = '0;
          trunc_nxt  = 1'b0;
          rd_addr    = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
          rd_addr = idx_r + 1'b1;
        end
      end
    end else if (!qstat.empty) begin
      priority if (mode_r == MODE_IDENT &&
                   (head.cls == CL_WORD || head.cls == CL_DIGIT)) begin
        pop = 1'b1;
        if (id_len_r < LEN_W'(MAX_IDENT)) begin
          wr_en      = 1'b1;
          id_len_nxt = id_len_r + 1'b1;
        end else begin
          trunc_nxt = 1'b1;
        end
      end else if (mode_r == MODE_INT && head.cls == CL_DIGIT) begin
        pop         = 1'b1;
        int_acc_nxt = int_times10 + INT_W'(digit);
      end else if (mode_r == MODE_INT && head.cls == CL_DOT) begin
        pop      = 1'b1;
        mode_nxt = MODE_FRAC;
      end else if (mode_r == MODE_FRAC && head.cls == CL_DIGIT) begin
        pop = 1'b1;
        if (frac_cnt_r < FLEN_W'(MAX_FRAC_DIGITS)) begin
          frac_acc_nxt = frac_times10 + FRAC_W'(digit);
          frac_cnt_nxt = frac_cnt_r + 1'b1;
        end
      end else if (mode_r == MODE_IDENT) begin
        // start replaying the buffered identifier, item stays queued
        st_nxt  = ST_SYM;
        idx_nxt = '0;
        rd_addr = '0;
      end else if (mode_r == MODE_INT || mode_r == MODE_FRAC) begin
        if (emit_ok) begin
          load         = 1'b1;
          o_kind       = (mode_r == MODE_INT) ? KIND_INT : KIND_DEC;
          o_int        = int_acc_r;
          o_frac       = frac_acc_r;
          o_flen       = frac_cnt_r;
          o_last       = !follow;
          mode_nxt     = MODE_IDLE;
          int_acc_nxt  = '0;
          frac_acc_nxt = '0;
          frac_cnt_nxt = '0;
        end
      end else begin
        unique case (head.cls)
          CL_OP: begin
            if (emit_ok) begin
              load   = 1'b1;
              o_kind = head.opk;
              o_last = 1'b1;
              pop    = 1'b1;
            end
          end
          CL_END: begin
            if (emit_ok) begin
              load   = 1'b1;
              o_kind = KIND_END;
              o_last = 1'b1;
              pop    = 1'b1;
            end
          end
          CL_WORD: begin
            pop        = 1'b1;
            mode_nxt   = MODE_IDENT;
            wr_en      = 1'b1;
            wr_addr    = '0;
            id_len_nxt = LEN_W'(1);
            trunc_nxt  = 1'b0;
          end
          CL_DIGIT: begin
            pop          = 1'b1;
            mode_nxt     = MODE_INT;
            int_acc_nxt  = INT_W'(digit);
            frac_acc_nxt = '0;
            frac_cnt_nxt = '0;
          end
          default: begin
            pop = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_SCAN;
      mode_r      <= MODE_IDLE;
      int_acc_r   <= '0;
      frac_acc_r  <= '0;
      frac_cnt_r  <= '0;
      id_len_r    <= '0;
      trunc_r     <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      mode_r     <= mode_nxt;
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      frac_cnt_r <= frac_cnt_nxt;
      id_len_r   <= id_len_nxt;
      trunc_r    <= trunc_nxt;
      idx_r      <= idx_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r  <= o_kind;
      out_char_r  <= o_char;
      out_int_r   <= o_int;
      out_frac_r  <= o_frac;
      out_flen_r  <= o_flen;
      out_trunc_r <= o_trunc;
      out_last_r  <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= wr_data;
    end
    rdata_r <= buf_mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_char_value      = out_char_r;
  assign out_int_value       = out_int_r;
  assign out_fraction_value  = out_frac_r;
  assign out_fraction_length = out_flen_r;
  assign out_ident_truncated = out_trunc_r;
  assign out_last            = out_last_r;

endmodule

/* rtl/calculator_token_scanner.sv */
// ----------------------------------------------------------------------------
// calculator_token_scanner
// lexical scanner for arithmetic expression text, one character per transaction
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid/in_ready carries one ascii character (in_ch) or an
//   end-of-text marker (in_end_of_text); output channel: out_valid/out_ready
//   carries one token field set per transaction, out_last marks the final
//   token caused by an input character
//   the front classifies each character and writes it into a small queue;
//   the back holds the scan state and emits tokens into one output register
//   a character is first written into the queue; the back then reads it at
//   the queue head, and a token it produces is loaded into the output register
//   the back takes a character that extends or starts a token without
//   emitting; ending a number before an operator first emits the number,
//   then the operator; ending an identifier starts the buffer read, then
//   emits one token per buffered character, then handles the ending character
//   the input side keeps accepting while the queue has room, so short
//   receiver stalls are absorbed by the queue and the output register
//   reset: synchronous, active low; clears the queue, the scan state and
//   out_valid; the identifier buffer is not cleared and needs no sweep
// ----------------------------------------------------------------------------
module calculator_token_scanner #(
  parameter int MAX_IDENT       = cts_pkg::CTS_MAX_IDENT,
  parameter int MAX_FRAC_DIGITS = cts_pkg::CTS_MAX_FRAC_DIGITS,
  parameter int QUEUE_DEPTH     = cts_pkg::CTS_QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [cts_pkg::CH_W-1:0]   in_ch,
  input  logic                       in_end_of_text,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cts_pkg::KIND_W-1:0] out_kind,
  output logic [cts_pkg::CH_W-1:0]   out_char_value,
  output logic [cts_pkg::INT_W-1:0]  out_int_value,
  output logic [cts_pkg::FRAC_W-1:0] out_fraction_value,
  output logic [cts_pkg::FLEN_W-1:0] out_fraction_length,
  output logic                       out_ident_truncated,
  output logic                       out_last
);
  import cts_pkg::*;

  // queue status and traffic between front and back
  cts_qstat_t qstat;
  cts_item_t  push_item;
  cts_item_t  head;
  logic       push;
  logic       pop;

  // classify and enqueue
  cts_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_ch          (in_ch),
    .in_end_of_text (in_end_of_text),
    .qstat          (qstat),
    .push           (push),
    .push_item      (push_item)
  );

  // decouples character intake from token emission
  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // scan state machine and token output register
  cts_back #(
    .MAX_IDENT       (MAX_IDENT),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head                (head),
    .qstat               (qstat),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_char_value      (out_char_value),
    .out_int_value       (out_int_value),
    .out_fraction_value  (out_fraction_value),
    .out_fraction_length (out_fraction_length),
    .out_ident_truncated (out_ident_truncated),
    .out_last            (out_last)
  );

  // an accepted character is queued until the back takes it
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !qstat.empty)
    else $error("accepted character missing from queue");

  // the back never takes from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // an end token always closes the transaction group
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_END) |-> out_last)
    else $error("end token without last");

  // only decimal tokens carry fraction digits
  a_flen_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != KIND_DEC) |-> (out_fraction_length == '0))
    else $error("fraction length on non-decimal token");

endmodule
